@@ design/rau_pkg.sv @@
`default_nettype none

package rau_pkg;

    // Operation codes
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_ABS = 3'd4;
    localparam logic [2:0] CMD_POW = 3'd5;

    localparam int unsigned EXP_WIDTH = 16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_P0,
        S_ADD_P1,
        S_ADD_P2,
        S_ADD_SUM,
        S_MUL_P0,
        S_MUL_P1,
        S_DIV_P0,
        S_DIV_P1,
        S_DIV_SGN,
        S_PW_TEST,
        S_PW_ACCN,
        S_PW_ACCD,
        S_PW_SQN,
        S_PW_SQD,
        S_RED,
        S_GCD,
        S_GCD_W,
        S_QN,
        S_QN_W,
        S_QD,
        S_QD_W,
        S_FIX,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ design/rau_div.sv @@
`default_nettype none

// Signed truncating divider, one quotient bit per cycle.
// Quotient sign follows both operands, remainder sign follows the dividend.
module rau_div #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire logic signed [DATA_WIDTH-1:0] i_dividend,
    input  wire logic signed [DATA_WIDTH-1:0] i_divisor,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_quotient,
    output logic signed [DATA_WIDTH-1:0] o_remainder
);

    localparam int unsigned CW = $clog2(DATA_WIDTH + 1);
    localparam logic [CW-1:0] CNT_LOAD = CW'(DATA_WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(1);
    localparam logic [DATA_WIDTH-1:0] ZERO = '0;

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_dsr;
    logic                  r_neg_q;
    logic                  r_neg_r;

    logic [DATA_WIDTH-1:0] w_mag_a;
    logic [DATA_WIDTH-1:0] w_mag_b;
    logic [DATA_WIDTH:0]   w_rem_sh;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_ge;

    assign w_mag_a  = i_dividend[DATA_WIDTH-1] ? (ZERO - i_dividend) : i_dividend;
    assign w_mag_b  = i_divisor[DATA_WIDTH-1]  ? (ZERO - i_divisor)  : i_divisor;
    assign w_rem_sh = {r_rem, r_quo[DATA_WIDTH-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dsr};
    assign w_ge     = ~w_diff[DATA_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LOAD;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_LAST;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= w_mag_a;
            r_dsr   <= w_mag_b;
            r_neg_q <= i_dividend[DATA_WIDTH-1] ^ i_divisor[DATA_WIDTH-1];
            r_neg_r <= i_dividend[DATA_WIDTH-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DATA_WIDTH-1:0] : w_rem_sh[DATA_WIDTH-1:0];
            r_quo <= {r_quo[DATA_WIDTH-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? (ZERO - r_quo) : r_quo;
    assign o_remainder = r_neg_r ? (ZERO - r_rem) : r_rem;

endmodule

`default_nettype wire

@@ design/rational_arithmetic_unit_top.sv @@
`default_nettype none

// Rational arithmetic unit. Takes one item (operation code, fractions a and b,
// exponent) and returns one reduced fraction. Add, subtract, multiply, divide,
// absolute value and integer power are supported; every intermediate value
// wraps to DATA_WIDTH bits in two's complement. The result is reduced by a
// Euclidean GCD with truncating remainder and its denominator made positive
// (the most negative value stays negative after negation). A zero numerator
// gives 0/1, a zero exponent gives 1/1, a zero denominator gives 1/0, and an
// undefined operation code gives 0/1. One item is handled at a time; o_ready
// is low from acceptance until the result is taken. The work uses one shared
// multiplier (one product per cycle) and one shared bit-serial divider:
// add/subtract form three products and a sum, multiply two products, divide
// two products and a sign move, and power tests each bit of the 16-bit
// exponent, multiplies the accumulators in on a one bit, squares the base
// numerator and denominator, and ends with one final test. The reduction then
// runs one division per Euclid step (at most about 1.5 * DATA_WIDTH steps,
// typically a handful), two more divisions, then fix-up and output.
module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire logic [2:0]                    i_cmd,
    input  wire logic signed [DATA_WIDTH-1:0]  i_a_numerator,
    input  wire logic signed [DATA_WIDTH-1:0]  i_a_denominator,
    input  wire logic signed [DATA_WIDTH-1:0]  i_b_numerator,
    input  wire logic signed [DATA_WIDTH-1:0]  i_b_denominator,
    input  wire logic [EXP_WIDTH-1:0]          i_exponent,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic signed [DATA_WIDTH-1:0]       o_result_numerator,
    output logic signed [DATA_WIDTH-1:0]       o_result_denominator
);

    localparam logic [DATA_WIDTH-1:0] ZERO = '0;
    localparam logic [DATA_WIDTH-1:0] ONE  = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    t_state r_state, n_state;

    // Operands and working registers
    logic [2:0]            r_cmd,  n_cmd;
    logic [DATA_WIDTH-1:0] r_an,   n_an;
    logic [DATA_WIDTH-1:0] r_ad,   n_ad;
    logic [DATA_WIDTH-1:0] r_bn,   n_bn;
    logic [DATA_WIDTH-1:0] r_bd,   n_bd;
    logic [EXP_WIDTH-1:0]  r_exp,  n_exp;
    logic [DATA_WIDTH-1:0] r_num,  n_num;
    logic [DATA_WIDTH-1:0] r_den,  n_den;
    logic [DATA_WIDTH-1:0] r_t,    n_t;
    logic [DATA_WIDTH-1:0] r_gx,   n_gx;
    logic [DATA_WIDTH-1:0] r_gy,   n_gy;

    // Shared multiplier: wrapped product of two registers, captured the same cycle
    logic [DATA_WIDTH-1:0]   mul_a;
    logic [DATA_WIDTH-1:0]   mul_b;
    logic [2*DATA_WIDTH-1:0] w_full;
    logic [DATA_WIDTH-1:0]   w_prod;

    assign w_full = mul_a * mul_b;
    assign w_prod = w_full[DATA_WIDTH-1:0];

    // Shared divider
    logic                         div_start;
    logic [DATA_WIDTH-1:0]        div_a;
    logic [DATA_WIDTH-1:0]        div_b;
    logic                         div_done;
    logic signed [DATA_WIDTH-1:0] div_quo;
    logic signed [DATA_WIDTH-1:0] div_rem;

    rau_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_an  <= n_an;
        r_ad  <= n_ad;
        r_bn  <= n_bn;
        r_bd  <= n_bd;
        r_exp <= n_exp;
        r_num <= n_num;
        r_den <= n_den;
        r_t   <= n_t;
        r_gx  <= n_gx;
        r_gy  <= n_gy;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_an      = r_an;
        n_ad      = r_ad;
        n_bn      = r_bn;
        n_bd      = r_bd;
        n_exp     = r_exp;
        n_num     = r_num;
        n_den     = r_den;
        n_t       = r_t;
        n_gx      = r_gx;
        n_gy      = r_gy;
        mul_a     = r_an;
        mul_b     = r_bd;
        div_start = 1'b0;
        div_a     = r_gy;
        div_b     = r_gx;
        o_ready   = 1'b0;
        o_valid   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd = i_cmd;
                    n_an  = i_a_numerator;
                    n_ad  = i_a_denominator;
                    n_bn  = i_b_numerator;
                    n_bd  = i_b_denominator;
                    n_exp = i_exponent;
                    unique case (i_cmd) inside
                        CMD_ADD, CMD_SUB: n_state = S_ADD_P0;
                        CMD_MUL:          n_state = S_MUL_P0;
                        CMD_DIV:          n_state = S_DIV_P0;
                        CMD_ABS: begin
                            n_num   = i_a_numerator[DATA_WIDTH-1] ?
                                      (ZERO - i_a_numerator) : i_a_numerator;
                            n_den   = i_a_denominator[DATA_WIDTH-1] ?
                                      (ZERO - i_a_denominator) : i_a_denominator;
                            n_state = S_RED;
                        end
                        CMD_POW: begin
                            if (i_exponent == '0) begin
                                n_num   = ONE;
                                n_den   = ONE;
                                n_state = S_OUT;
                            end else if (i_a_numerator == ZERO) begin
                                n_num   = ZERO;
                                n_den   = ONE;
                                n_state = S_OUT;
                            end else begin
                                // accumulators start at one
                                n_num   = ONE;
                                n_den   = ONE;
                                n_state = S_PW_TEST;
                            end
                        end
                        default: begin
                            n_num   = ZERO;
                            n_den   = ONE;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            // Add/subtract: an*bd +/- bn*ad over ad*bd
            S_ADD_P0: begin
                mul_a   = r_an;
                mul_b   = r_bd;
                n_num   = w_prod;
                n_state = S_ADD_P1;
            end
            S_ADD_P1: begin
                mul_a   = r_bn;
                mul_b   = r_ad;
                n_t     = w_prod;
                n_state = S_ADD_P2;
            end
            S_ADD_P2: begin
                mul_a   = r_ad;
                mul_b   = r_bd;
                n_den   = w_prod;
                n_state = S_ADD_SUM;
            end
            S_ADD_SUM: begin
                n_num   = (r_cmd == CMD_SUB) ? (r_num - r_t) : (r_num + r_t);
                n_state = S_RED;
            end

            S_MUL_P0: begin
                mul_a   = r_an;
                mul_b   = r_bn;
                n_num   = w_prod;
                n_state = S_MUL_P1;
            end
            S_MUL_P1: begin
                mul_a   = r_ad;
                mul_b   = r_bd;
                n_den   = w_prod;
                n_state = S_RED;
            end

            // Divide: an*bd over bn*ad, sign moved to the numerator
            S_DIV_P0: begin
                mul_a   = r_an;
                mul_b   = r_bd;
                n_num   = w_prod;
                n_state = S_DIV_P1;
            end
            S_DIV_P1: begin
                mul_a   = r_bn;
                mul_b   = r_ad;
                n_den   = w_prod;
                n_state = S_DIV_SGN;
            end
            S_DIV_SGN: begin
                if (r_den[DATA_WIDTH-1]) begin
                    n_num = ZERO - r_num;
                    n_den = ZERO - r_den;
                end
                n_state = S_RED;
            end

            // Power by repeated squaring, numerator and denominator in turn
            S_PW_TEST: begin
                if (r_exp == '0) begin
                    n_state = S_RED;
                end else if (r_exp[0]) begin
                    n_state = S_PW_ACCN;
                end else begin
                    n_state = S_PW_SQN;
                end
            end
            S_PW_ACCN: begin
                mul_a   = r_num;
                mul_b   = r_an;
                n_num   = w_prod;
                n_state = S_PW_ACCD;
            end
            S_PW_ACCD: begin
                mul_a   = r_den;
                mul_b   = r_ad;
                n_den   = w_prod;
                n_state = S_PW_SQN;
            end
            S_PW_SQN: begin
                mul_a   = r_an;
                mul_b   = r_an;
                n_an    = w_prod;
                n_state = S_PW_SQD;
            end
            S_PW_SQD: begin
                mul_a   = r_ad;
                mul_b   = r_ad;
                n_ad    = w_prod;
                n_exp   = r_exp >> 1;
                n_state = S_PW_TEST;
            end

            // Reduction
            S_RED: begin
                if (r_num == ZERO) begin
                    n_den   = ONE;
                    n_state = S_OUT;
                end else begin
                    n_gx    = r_num;
                    n_gy    = r_den;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_gx == ZERO) begin
                    n_state = S_QN;
                end else begin
                    div_start = 1'b1;
                    div_a     = r_gy;
                    div_b     = r_gx;
                    n_state   = S_GCD_W;
                end
            end
            S_GCD_W: begin
                if (div_done) begin
                    n_gy    = r_gx;
                    n_gx    = div_rem;
                    n_state = S_GCD;
                end
            end
            S_QN: begin
                div_start = 1'b1;
                div_a     = r_num;
                div_b     = r_gy;
                n_state   = S_QN_W;
            end
            S_QN_W: begin
                if (div_done) begin
                    n_num   = div_quo;
                    n_state = S_QD;
                end
            end
            S_QD: begin
                div_start = 1'b1;
                div_a     = r_den;
                div_b     = r_gy;
                n_state   = S_QD_W;
            end
            S_QD_W: begin
                if (div_done) begin
                    n_den   = div_quo;
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // make the denominator positive; the most negative value stays
                if (r_den[DATA_WIDTH-1]) begin
                    n_num = ZERO - r_num;
                    n_den = ZERO - r_den;
                end
                n_state = S_OUT;
            end

            // Hold the result until it is taken
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result_numerator   = r_num;
    assign o_result_denominator = r_den;

endmodule

`default_nettype wire
